// ===== hdl/cdcs_pkg.sv =====
package cdcs_pkg;

  localparam int DayW   = 6;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int LenW   = 5;
  localparam int OrderW = 2;

  // Divisibility by 25 through a reciprocal: q = (y * Recip25) >> Shift25
  // is exact for every 14-bit year.
  localparam int ProdW   = 29;
  localparam int Shift25 = 19;
  localparam int QuotW   = ProdW - Shift25;
  localparam logic [14:0] Recip25 = 15'd20972;
  localparam logic [4:0]  Div25   = 5'd25;

  localparam logic [YearW-1:0]  YearMax  = 14'd10000;
  localparam logic [DayW-1:0]   DayMax   = 6'd63;
  localparam logic [DayW-1:0]   DayFirst = 6'd1;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] MonthMax = 4'd15;

  typedef enum logic [OrderW-1:0] {
    ORDER_BEFORE = 2'd0,
    ORDER_EQUAL  = 2'd1,
    ORDER_AFTER  = 2'd2
  } order_t;

  // Stage-3 inputs: date A with its derived month facts.
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [LenW-1:0]   len;
  } date_info_t;

  // Stage-3 outputs: checks and the following day.
  typedef struct packed {
    logic              is_valid;
    logic              is_month_end;
    logic [DayW-1:0]   next_day;
    logic [MonthW-1:0] next_month;
    logic [YearW-1:0]  next_year;
  } step_res_t;

  function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [LenW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/cdcs_if.sv =====
interface cdcs_req_if;
  import cdcs_pkg::*;
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   a_day;
  logic [MonthW-1:0] a_month;
  logic [YearW-1:0]  a_year;
  logic [DayW-1:0]   b_day;
  logic [MonthW-1:0] b_month;
  logic [YearW-1:0]  b_year;

  modport source (output valid, a_day, a_month, a_year, b_day, b_month, b_year,
                  input ready);
  modport sink   (input valid, a_day, a_month, a_year, b_day, b_month, b_year,
                  output ready);
endinterface

interface cdcs_rsp_if;
  import cdcs_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_valid;
  logic              is_leap;
  logic [LenW-1:0]   month_length;
  logic              is_month_end;
  logic [DayW-1:0]   next_day;
  logic [MonthW-1:0] next_month;
  logic [YearW-1:0]  next_year;
  logic [OrderW-1:0] order;

  modport source (output valid, is_valid, is_leap, month_length, is_month_end,
                  next_day, next_month, next_year, order, input ready);
  modport sink   (input valid, is_valid, is_leap, month_length, is_month_end,
                  next_day, next_month, next_year, order, output ready);
endinterface

// ===== hdl/cdcs_next_date.sv =====
module cdcs_next_date (
  input  cdcs_pkg::date_info_t info,
  output cdcs_pkg::step_res_t  res
);
  import cdcs_pkg::*;

  logic             mend;
  logic [YearW:0]   year_inc;
  logic [YearW:0]   year_raw;
  logic [MonthW:0]  month_inc;

  assign mend      = ({1'b0, info.len} == info.day);
  assign year_inc  = {1'b0, info.year} + {{YearW{1'b0}}, 1'b1};
  assign month_inc = {1'b0, info.month} + {{MonthW{1'b0}}, 1'b1};

  always_comb begin
    res.is_month_end = mend;
    res.is_valid     = (info.day != '0) && (info.len != '0) &&
                       (info.day <= {1'b0, info.len});
    year_raw         = {1'b0, info.year};
    if (mend) begin
      res.next_day = DayFirst;
      if (info.month == MonthDec) begin
        res.next_month = MonthJan;
        year_raw       = year_inc;
      end else if (month_inc > {1'b0, MonthMax}) begin
        res.next_month = MonthMax;
      end else begin
        res.next_month = month_inc[MonthW-1:0];
      end
    end else begin
      res.next_month = info.month;
      // hold at the top of the field
      res.next_day   = (info.day == DayMax) ? DayMax : info.day + DayFirst;
    end
    res.next_year = (year_raw > {1'b0, YearMax}) ? YearMax : year_raw[YearW-1:0];
  end

endmodule

// ===== hdl/calendar_date_check_and_step_top.sv =====
// Gregorian date check and one-day step, three register stages.
// Throughput: one word per cycle while rsp.ready is high; a stalled result
// holds its stage and every full stage before it, while empty stages still fill.
// Reset (rst, synchronous, active high) empties all stages; only the valid bits are reset.
module calendar_date_check_and_step_top (
  input logic      clk,
  input logic      rst,
  cdcs_req_if.sink req,
  cdcs_rsp_if.source rsp
);
  import cdcs_pkg::*;

  // Stage valid bits and per-stage advance enables. A stage loads when it
  // is empty or when the stage after it takes its word.
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3 = !v3 || rsp.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  // Stage 1: register date A, start the divide-by-25 product on the year,
  // and settle the A-versus-B ordering on the raw fields.
  logic [DayW-1:0]   s1_day;
  logic [MonthW-1:0] s1_month;
  logic [YearW-1:0]  s1_year;
  logic [ProdW-1:0]  s1_prod;
  order_t            s1_order;
  order_t            order_next;

  always_comb begin
    if (req.a_year != req.b_year) begin
      order_next = (req.a_year < req.b_year) ? ORDER_BEFORE : ORDER_AFTER;
    end else if (req.a_month != req.b_month) begin
      order_next = (req.a_month < req.b_month) ? ORDER_BEFORE : ORDER_AFTER;
    end else if (req.a_day != req.b_day) begin
      order_next = (req.a_day < req.b_day) ? ORDER_BEFORE : ORDER_AFTER;
    end else begin
      order_next = ORDER_EQUAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid;
    end
    if (en1) begin
      s1_day   <= req.a_day;
      s1_month <= req.a_month;
      s1_year  <= req.a_year;
      s1_prod  <= ProdW'(req.a_year) * ProdW'(Recip25);
      s1_order <= order_next;
    end
  end

  // Stage 2: finish the leap test and look up the month length.
  // Leap: divisible by 4 and not by 100, or by 400; with 25 as the odd
  // factor that is div4 && (!div25 || div16).
  logic [QuotW-1:0]   quot;
  logic [YearW:0]     back;
  logic               div25;
  logic               leap_next;
  logic               s2_leap;
  date_info_t         s2_info;
  order_t             s2_order;

  assign quot      = s1_prod[ProdW-1:Shift25];
  assign back      = (YearW+1)'(quot) * (YearW+1)'(Div25);
  assign div25     = (back == {1'b0, s1_year});
  assign leap_next = (s1_year[1:0] == 2'b00) && (!div25 || (s1_year[3:0] == 4'b0000));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      s2_leap        <= leap_next;
      s2_info.day    <= s1_day;
      s2_info.month  <= s1_month;
      s2_info.year   <= s1_year;
      s2_info.len    <= month_len(s1_month, leap_next);
      s2_order       <= s1_order;
    end
  end

  // Stage 3: month-end, validity and the following day, into the output
  // register.
  step_res_t step;
  step_res_t s3_step;
  logic      s3_leap;
  logic [LenW-1:0] s3_len;
  order_t    s3_order;

  cdcs_next_date u_next (
    .info (s2_info),
    .res  (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      s3_step  <= step;
      s3_leap  <= s2_leap;
      s3_len   <= s2_info.len;
      s3_order <= s2_order;
    end
  end

  assign rsp.valid        = v3;
  assign rsp.is_valid     = s3_step.is_valid;
  assign rsp.is_leap      = s3_leap;
  assign rsp.month_length = s3_len;
  assign rsp.is_month_end = s3_step.is_month_end;
  assign rsp.next_day     = s3_step.next_day;
  assign rsp.next_month   = s3_step.next_month;
  assign rsp.next_year    = s3_step.next_year;
  assign rsp.order        = s3_order;

  // A full pipeline with a stalled result must refuse new words.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !rsp.ready) |-> !req.ready)
    else $error("input taken while pipeline full and stalled");

  // An accepted word always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> v1)
    else $error("accepted word lost at stage 1");

  // A valid date has a real month; a month end always steps to day one.
  a_valid_len: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_valid) |-> (rsp.month_length != '0))
    else $error("valid date with zero month length");

  a_mend_day: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_month_end) |-> (rsp.next_day == DayFirst))
    else $error("month end without step to day one");

endmodule
